// ===== hdl/latency_criticality_score_defines.svh =====
// Assertion macros for the latency criticality scorer.
`ifndef LATENCY_CRITICALITY_SCORE_DEFINES_SVH
`define LATENCY_CRITICALITY_SCORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LCS_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcs check failed");
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcs check failed");
`else
`define LCS_ASSERT(label, clk, rst_n, ante, cons)
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/lcs_pkg.sv =====
// Shared types, constants and the divider step for the criticality scorer.
`default_nettype none
package lcs_pkg;
	localparam int FREQ_W = 32;
	localparam int RUNTIME_W = 48;
	localparam int WEIGHT_W = 32;
	localparam int SCORE_IN_W = 16;
	localparam int SHIFT_W = 6;
	localparam int CRIT_W = 16;
	localparam int DIVIDEND_W = 48;
	localparam int DIVISOR_W = 32;
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES = DIVIDEND_W / DIV_BITS_PER_STAGE;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int IN_DATA_W = 176;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREQ_CAP       = 3'd0,
		CFG_RUNTIME_CEIL   = 3'd1,
		CFG_RUNTIME_DIV    = 3'd2,
		CFG_BONUS_SHIFT    = 3'd3,
		CFG_CAP_SHIFT      = 3'd4
	} cfg_idx_t;

	// remainder plus a word that holds dividend bits on top, quotient bits below
	typedef struct packed {
		logic [DIVISOR_W-1:0]  rem;
		logic [DIVIDEND_W-1:0] nq;
	} div_state_t;

	function automatic div_state_t div_step(div_state_t s, logic [DIVISOR_W-1:0] d);
		logic [DIVISOR_W:0] t;
		logic qb;
		div_state_t r;
		t = {s.rem, s.nq[DIVIDEND_W-1]};
		qb = (t >= {1'b0, d});
		if (qb) begin
			t = t - {1'b0, d};
		end
		r.rem = t[DIVISOR_W-1:0];
		r.nq = {s.nq[DIVIDEND_W-2:0], qb};
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/lcs_divider.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
`default_nettype none
module lcs_divider #(
	parameter int SIDE_W = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [lcs_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [lcs_pkg::DIVISOR_W-1:0]  divisor,
	input  wire logic [SIDE_W-1:0]             in_side,
	output logic                               out_valid,
	output logic [lcs_pkg::DIVIDEND_W-1:0]     quotient,
	output logic [SIDE_W-1:0]                  out_side
);
	import lcs_pkg::*;

	logic                  vld_s  [DIV_STAGES];
	div_state_t            st_s   [DIV_STAGES];
	logic [SIDE_W-1:0]     side_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		div_state_t        st_in;
		div_state_t        st_out;
		logic              v_in;
		logic [SIDE_W-1:0] sd_in;

		if (g == 0) begin : g_first
			assign st_in = '{rem: '0, nq: dividend};
			assign v_in = in_valid;
			assign sd_in = in_side;
		end else begin : g_next
			assign st_in = st_s[g-1];
			assign v_in = vld_s[g-1];
			assign sd_in = side_s[g-1];
		end

		always_comb begin
			st_out = st_in;
			for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
				st_out = div_step(st_out, divisor);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g] <= st_out;
				side_s[g] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quotient = st_s[DIV_STAGES-1].nq;
	assign out_side = side_s[DIV_STAGES-1];
endmodule
`default_nettype wire

// ===== hdl/lcs_log2.sv =====
// Two-stage floor log2 of a 64-bit word; zero gives zero.
`default_nettype none
module lcs_log2 (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] value,
	output logic [5:0]       lg
);
	import lcs_pkg::*;

	logic [3:0] nz_s1;
	logic [3:0] pos_s1 [4];
	logic [3:0] nz_c;
	logic [3:0] pos_c [4];
	logic [5:0] lg_c;
	logic [5:0] lg_s2;

	// per 16-bit chunk: any bit set, and top set bit
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			nz_c[c] = |value[c*16 +: 16];
			pos_c[c] = '0;
			for (int i = 0; i < 16; i++) begin
				if (value[c*16+i]) begin
					pos_c[c] = 4'(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nz_s1 <= nz_c;
			pos_s1 <= pos_c;
		end
	end

	always_comb begin
		lg_c = '0;
		for (int c = 0; c < 4; c++) begin
			if (nz_s1[c]) begin
				lg_c = {2'(c), pos_s1[c]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lg_s2 <= lg_c;
		end
	end

	assign lg = lg_s2;
endmodule
`default_nettype wire

// ===== hdl/latency_criticality_score.sv =====
// Top level of the latency criticality scorer.
// One task record enters per cycle unless stalled, and one 16-bit score leaves per
// record, in order, through an input stage, 24 divider stages (two bits of the 48-bit
// headroom quotient each), two multiply and two log2 stages, then sum, square, bonus and
// output stages. A stalled output freezes the whole pipeline; s_tready follows m_tready
// combinationally while the output holds a beat. The user, not the block, must ensure
// registers are written via cfg_we/cfg_index/cfg_data only while no beat is in flight.
`default_nettype none
`include "latency_criticality_score_defines.svh"
module latency_criticality_score (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// wait rate, wake rate, average runtime, weight, waker score, wakee score
	input  wire logic [lcs_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// criticality
	output logic [lcs_pkg::CRIT_W-1:0]        m_tdata
);
	import lcs_pkg::*;

	localparam int SIDE_W = 33 + 33 + WEIGHT_W + 17;

	logic [FREQ_W-1:0]    freq_cap_q;
	logic [RUNTIME_W-1:0] ceil_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [SHIFT_W-1:0]   gshift_q;
	logic [SHIFT_W-1:0]   rshift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_cap_q <= 32'd100000;
			ceil_q <= 48'd5000000;
			div_q <= 32'd1000;
			gshift_q <= 6'd1;
			rshift_q <= 6'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FREQ_CAP:       freq_cap_q <= cfg_data[FREQ_W-1:0];
				CFG_RUNTIME_CEIL:   ceil_q <= cfg_data[RUNTIME_W-1:0];
				// zero divisor acts as one
				CFG_RUNTIME_DIV:    div_q <= (cfg_data[DIVISOR_W-1:0] == '0) ? 32'd1 :
				                             cfg_data[DIVISOR_W-1:0];
				CFG_BONUS_SHIFT:    gshift_q <= cfg_data[SHIFT_W-1:0];
				CFG_CAP_SHIFT:      rshift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s9;
	assign en = !v_s9 || m_tready;
	assign s_tready = en;

	// input fields
	logic [FREQ_W-1:0]     in_wait, in_wake;
	logic [RUNTIME_W-1:0]  in_rt;
	logic [WEIGHT_W-1:0]   in_weight;
	logic [SCORE_IN_W-1:0] in_waker, in_wakee;
	assign in_wait   = s_tdata[31:0];
	assign in_wake   = s_tdata[63:32];
	assign in_rt     = s_tdata[111:64];
	assign in_weight = s_tdata[143:112];
	assign in_waker  = s_tdata[159:144];
	assign in_wakee  = s_tdata[175:160];

	// stage 1: clamp, headroom, giver sum
	logic                 v_s1;
	logic [32:0]          waitf_s1, wakef_s1;
	logic [RUNTIME_W-1:0] head_s1;
	logic [WEIGHT_W-1:0]  weight_s1;
	logic [16:0]          giver_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			waitf_s1 <= {1'b0, (in_wait < freq_cap_q) ? in_wait : freq_cap_q} + 33'd1;
			wakef_s1 <= {1'b0, (in_wake < freq_cap_q) ? in_wake : freq_cap_q} + 33'd1;
			head_s1 <= (ceil_q > in_rt) ? ceil_q - in_rt : '0;
			weight_s1 <= in_weight;
			giver_s1 <= {1'b0, in_waker} + {1'b0, in_wakee};
		end
	end

	logic                  v_dv;
	logic [DIVIDEND_W-1:0] quo_dv;
	logic [SIDE_W-1:0]     side_dv;

	lcs_divider #(.SIDE_W(SIDE_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.dividend  (head_s1),
		.divisor   (div_q),
		.in_side   ({waitf_s1, wakef_s1, weight_s1, giver_s1}),
		.out_valid (v_dv),
		.quotient  (quo_dv),
		.out_side  (side_dv)
	);

	logic [32:0]         waitf_dv, wakef_dv;
	logic [WEIGHT_W-1:0] weight_dv;
	logic [16:0]         giver_dv;
	assign {waitf_dv, wakef_dv, weight_dv, giver_dv} = side_dv;

	// stage 2: partial products; run factor is quotient + 1, so add weight later
	logic                v_s2;
	logic [63:0]         rlo_s2;
	logic [31:0]         rhi_s2;
	logic [WEIGHT_W-1:0] weight_s2;
	logic [63:0]         flo_s2;
	logic                ah_s2, bh_s2;
	logic [31:0]         al_s2, bl_s2;
	logic [16:0]         giver_s2;
	logic [47:0]         rhi_full;
	assign rhi_full = quo_dv[47:32] * weight_dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rlo_s2 <= quo_dv[31:0] * weight_dv;
			rhi_s2 <= rhi_full[31:0];
			weight_s2 <= weight_dv;
			flo_s2 <= waitf_dv[31:0] * wakef_dv[31:0];
			ah_s2 <= waitf_dv[32];
			bh_s2 <= wakef_dv[32];
			al_s2 <= waitf_dv[31:0];
			bl_s2 <= wakef_dv[31:0];
			giver_s2 <= giver_dv;
		end
	end

	// stage 3: full products modulo 2^64
	logic        v_s3;
	logic [63:0] runp_s3, freqp_s3;
	logic [16:0] giver_s3;
	logic [32:0] fcorr;
	assign fcorr = (ah_s2 ? {1'b0, bl_s2} : 33'd0) + (bh_s2 ? {1'b0, al_s2} : 33'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			runp_s3 <= rlo_s2 + {rhi_s2, 32'd0} + {32'd0, weight_s2};
			freqp_s3 <= flo_s2 + {fcorr[31:0], 32'd0};
			giver_s3 <= giver_s2;
		end
	end

	// stages 4 and 5: log2 units
	logic [5:0]  lg_run, lg_freq;
	logic        v_s4, v_s5;
	logic [16:0] giver_s4, giver_s5;

	lcs_log2 u_log_run (.clk(clk), .en(en), .value(runp_s3), .lg(lg_run));
	lcs_log2 u_log_freq (.clk(clk), .en(en), .value(freqp_s3), .lg(lg_freq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			giver_s4 <= giver_s3;
			giver_s5 <= giver_s4;
		end
	end

	// stage 6: sum, stage 7: square
	logic        v_s6, v_s7;
	logic [6:0]  sum_s6;
	logic [13:0] score_s7;
	logic [16:0] giver_s6, giver_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= {1'b0, lg_run} + {1'b0, lg_freq};
			giver_s6 <= giver_s5;
			score_s7 <= sum_s6 * sum_s6;
			giver_s7 <= giver_s6;
		end
	end

	// stage 8: bonus candidates
	logic        v_s8;
	logic        over_s8;
	logic [16:0] bonus_s8;
	logic [13:0] cap_s8, score_s8;
	logic [16:0] twice;
	logic [16:0] excess;
	assign twice = {2'b0, score_s7, 1'b0};
	assign excess = giver_s7 - twice;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			over_s8 <= giver_s7 > twice;
			bonus_s8 <= excess >> gshift_q;
			cap_s8 <= score_s7 >> rshift_q;
			score_s8 <= score_s7;
		end
	end

	// stage 9: output register
	logic [CRIT_W-1:0] crit_s9;
	logic [13:0]       addon;
	assign addon = !over_s8 ? 14'd0 :
	               (bonus_s8 < {3'b0, cap_s8}) ? bonus_s8[13:0] : cap_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crit_s9 <= {2'b0, score_s8} + {2'b0, addon};
		end
	end

	assign m_tvalid = v_s9;
	assign m_tdata = crit_s9;

	`LCS_ASSERT(a_stall_blocks_input, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	`LCS_ASSERT(a_square_range, clk, arst_n, v_s7, score_s7 <= 14'd15876)
	`LCS_ASSERT_NEXT(a_bonus_never_lowers, clk, arst_n, v_s8 && en,
		m_tvalid && (crit_s9 >= {2'b0, $past(score_s8)}))
endmodule
`default_nettype wire
